FILE: sv/sfd_pkg.sv
// Package for the SLIP frame decoder: line codes, length limit and the
// result record that passes from the decode logic to the output register.
// No dependencies.
`default_nettype none

package sfd_pkg;

  // Special line codes
  localparam logic [7:0] CODE_FEND  = 8'hC0;
  localparam logic [7:0] CODE_FESC  = 8'hDB;
  localparam logic [7:0] CODE_TFEND = 8'hDC;
  localparam logic [7:0] CODE_TFESC = 8'hDD;

  // Largest payload a frame may hold; the counter must reach it
  localparam int MAX_LEN = 256;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 8;
  localparam int LEN_W   = 9;

  typedef struct packed {
    logic               data_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] data_index;
    logic               frame_done;
    logic [LEN_W-1:0]   frame_length;
    logic               overflow_end;
  } sfd_result_t;

endpackage

`default_nettype wire

FILE: sv/slip_frame_decoder.sv
// Top level of the SLIP frame decoder: input register, decode logic and
// result register on streaming channels. Depends on sfd_pkg, sfd_decode.
//
//   channel | dir | content
//   in_     | in  | tdata[7:0] in_byte
//   out_    | out | tdata byte/index/length, tuser valid/overflow, tlast done
//
// One result per input byte. A byte is held in the input register, is
// decoded on its way into the result register, and is offered from there;
// one byte per cycle is sustained while the output is ready. Reset clears
// the escape flag, framing flag, counter and both stage valids. A stall on
// the output holds both stages; the input stays ready while the input
// register is empty or moving on.
`default_nettype none

module slip_frame_decoder
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] data_byte, [15:8] data_index,
                                       // [24:16] frame_length, [31:25] zero
  output logic [1:0]       out_tuser,  // [0] data_valid, [1] overflow_end
  output logic             out_tlast   // frame_done
);

  logic              a_valid_r;
  logic [BYTE_W-1:0] a_byte_r;
  logic              b_valid_r;
  sfd_result_t       b_res_r;
  sfd_result_t       dec_res;
  logic              advance;

  assign advance   = a_valid_r && (!b_valid_r || out_tready);
  assign in_tready = !a_valid_r || advance;

  sfd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .in_byte (a_byte_r),
    .result  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
      if (advance) begin
        b_valid_r <= 1'b1;
      end else if (out_tready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_byte_r <= in_tdata;
    end
    if (advance) begin
      b_res_r <= dec_res;
    end
  end

  assign out_tvalid = b_valid_r;
  assign out_tdata  = {7'd0, b_res_r.frame_length, b_res_r.data_index, b_res_r.data_byte};
  assign out_tuser  = {b_res_r.overflow_end, b_res_r.data_valid};
  assign out_tlast  = b_res_r.frame_done;

endmodule

`default_nettype wire

FILE: sv/sfd_decode.sv
// Decode state (escape flag, framing flag, byte counter) and the
// per-byte logic that turns one line byte into one result record.
// Depends on sfd_pkg.
`default_nettype none

module sfd_decode
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,      // consume in_byte this cycle
  input  wire logic [BYTE_W-1:0] in_byte,
  output sfd_result_t            result
);

  logic             esc_r, esc_nxt;
  logic             frm_r, frm_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CNT_W+LEN_W-1:0] cnt_ext;

  assign cnt_ext = {{LEN_W{1'b0}}, cnt_r};

  always_comb begin
    logic [BYTE_W-1:0] c;
    logic              pass;
    logic              frm_eff;

    c       = in_byte;
    pass    = 1'b0;
    frm_eff = frm_r;
    esc_nxt = esc_r;
    frm_nxt = frm_r;
    cnt_nxt = cnt_r;
    result  = '0;

    if (esc_r) begin
      esc_nxt = 1'b0;
      pass    = 1'b1;
      if (in_byte == CODE_TFEND) begin
        c = CODE_FEND;
      end else if (in_byte == CODE_TFESC) begin
        c = CODE_FESC;
      end else begin
        // bad escape: drop framing until the next FEND
        frm_eff = 1'b0;
      end
    end else if (in_byte == CODE_FESC) begin
      esc_nxt = 1'b1;
    end else if (in_byte == CODE_FEND) begin
      if (!frm_r) begin
        frm_eff = 1'b1;
      end else if (cnt_r != '0) begin
        result.frame_done   = 1'b1;
        result.frame_length = cnt_ext[LEN_W-1:0];
      end
      cnt_nxt = '0;
    end else begin
      pass = 1'b1;
    end

    frm_nxt = frm_eff;

    if (pass && frm_eff) begin
      if (cnt_r < CNT_W'(MAX_LEN)) begin
        result.data_valid = 1'b1;
        result.data_byte  = c;
        result.data_index = cnt_ext[INDEX_W-1:0];
        cnt_nxt           = cnt_r + 1'b1;
      end else begin
        // limit reached: drop the byte and close the frame as overflow
        frm_nxt             = 1'b0;
        result.frame_done   = 1'b1;
        result.frame_length = cnt_ext[LEN_W-1:0];
        result.overflow_end = 1'b1;
        cnt_nxt             = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      frm_r <= 1'b0;
      cnt_r <= '0;
    end else if (step) begin
      esc_r <= esc_nxt;
      frm_r <= frm_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_slip_frame_decoder.sv
// Self-checking testbench for slip_frame_decoder: streams raw line bytes through
// the block and compares every decoded result against an in-bench SLIP decoder.
// Depends on sfd_pkg and slip_frame_decoder.

module tb_slip_frame_decoder
  import sfd_pkg::*;
();

  localparam int QUIET_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int BURST_HOLD     = 60;
  localparam int PHASE_ITEMS    = 170;
  localparam int MAX_REPORTS    = 50;

  // Tracks SLIP framing state and holds the decoded results still owed
  class sfd_decode_checker;
    sfd_result_t decoded_q[$];
    bit          esc_pending;
    bit          framing;
    logic [31:0] held;
    int          errors;

    function new();
      esc_pending = 1'b0;
      framing     = 1'b0;
      held        = '0;
      errors      = 0;
    endfunction

    // Decode one accepted line byte into the result the block owes for it
    function void decode_line_byte(logic [7:0] b);
      sfd_result_t r;
      logic [7:0]  c;
      r = '0;
      c = b;
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (c == CODE_TFEND) c = CODE_FEND;
        else if (c == CODE_TFESC) c = CODE_FESC;
        else framing = 1'b0;
      end else if (c == CODE_FESC) begin
        esc_pending = 1'b1;
        decoded_q.push_back(r);
        return;
      end else if (c == CODE_FEND) begin
        if (!framing) begin
          framing = 1'b1;
        end else if (held > 0) begin
          r.frame_done   = 1'b1;
          r.frame_length = held[LEN_W-1:0];
        end
        held = '0;
        decoded_q.push_back(r);
        return;
      end
      if (framing) begin
        if (held < MAX_LEN) begin
          r.data_valid = 1'b1;
          r.data_byte  = c;
          r.data_index = held[INDEX_W-1:0];
          held         = held + 1;
        end else begin
          // limit reached: drop the byte and end the frame
          framing        = 1'b0;
          r.frame_done   = 1'b1;
          r.frame_length = held[LEN_W-1:0];
          r.overflow_end = 1'b1;
          held           = '0;
        end
      end
      decoded_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < MAX_REPORTS)
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_decoded(logic [31:0] tdata, logic [1:0] tuser, logic tlast);
      sfd_result_t want;
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", tdata, '0);
        return;
      end
      want = decoded_q.pop_front();
      if (tuser[0] !== want.data_valid)
        report_mismatch("data_valid", tuser[0], want.data_valid);
      if (tdata[7:0] !== want.data_byte)    report_mismatch("data_byte", tdata[7:0], want.data_byte);
      if (tdata[15:8] !== want.data_index)  report_mismatch("data_index", tdata[15:8], want.data_index);
      if (tlast !== want.frame_done)        report_mismatch("frame_done", tlast, want.frame_done);
      if (tdata[24:16] !== want.frame_length)
        report_mismatch("frame_length", tdata[24:16], want.frame_length);
      if (tuser[1] !== want.overflow_end)
        report_mismatch("overflow_end", tuser[1], want.overflow_end);
      if (tdata[31:25] !== '0)              report_mismatch("tdata padding", tdata[31:25], '0);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  sfd_decode_checker decoder_chk = new();

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   sent_count = 0;
  int   quiet_cycles = 0;
  logic holding = 1'b0;
  event stall_burst_ev;

  slip_frame_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      decoder_chk.check_decoded(out_tdata, out_tuser, out_tlast);
    out_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off so the pipeline fills and input backs up
  always begin
    @(stall_burst_ev);
    holding <= 1'b1;
    repeat (BURST_HOLD) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decoder_chk.decode_line_byte(b);
    sent_count++;
  endtask

  // Payload byte with SLIP escaping applied
  task automatic send_payload_byte(logic [7:0] b);
    if (b == CODE_FEND) begin
      send_byte(CODE_FESC);
      send_byte(CODE_TFEND);
    end else if (b == CODE_FESC) begin
      send_byte(CODE_FESC);
      send_byte(CODE_TFESC);
    end else begin
      send_byte(b);
    end
  endtask

  // Random byte biased toward the four line codes
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       return CODE_FEND;
        1:       return CODE_FESC;
        2:       return CODE_TFEND;
        default: return CODE_TFESC;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame(int payload_len);
    send_byte(CODE_FEND);
    repeat (payload_len) send_payload_byte(pick_byte());
  endtask

  task automatic send_random_chunk();
    int         kind;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 78) begin
      send_frame(($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12));
    end else if (kind < 90) begin
      // raw noise, codes left unescaped
      repeat ($urandom_range(1, 6)) send_byte(pick_byte());
    end else begin
      // bad escape, after a truncated frame in half of the cases
      if ($urandom_range(1)) begin
        send_byte(CODE_FEND);
        repeat ($urandom_range(0, 4)) send_payload_byte(pick_byte());
      end
      do b = pick_byte(); while (b == CODE_TFEND || b == CODE_TFESC);
      send_byte(CODE_FESC);
      send_byte(b);
    end
  endtask

  initial begin
    int base;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bytes and escapes outside framing, empty frame, literals,
    // bad escapes, reopen after a dropped frame
    send_byte(8'h55);
    send_byte(CODE_FESC);
    send_byte(8'h12);
    send_byte(CODE_FEND);
    send_byte(CODE_FEND);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_payload_byte(CODE_FEND);
    send_payload_byte(CODE_FESC);
    send_byte(CODE_TFEND);
    send_byte(CODE_TFESC);
    send_byte(CODE_FEND);
    send_byte(8'h01);
    send_byte(CODE_FESC);
    send_byte(8'h41);
    send_byte(8'h22);
    send_byte(CODE_FEND);
    send_byte(CODE_FESC);
    send_byte(CODE_FEND);
    send_byte(CODE_FEND);
    send_byte(8'hAA);
    send_byte(CODE_FEND);

    base = sent_count;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (phase == 0) -> stall_burst_ev;
      // full-length frame, left open for whatever chunk follows
      if (phase == 1) send_frame(MAX_LEN);
      // one byte past the limit, plus trailing bytes that get ignored
      if (phase == 3) send_frame(MAX_LEN + 3);
      while (sent_count < base + PHASE_ITEMS * (phase + 1)) send_random_chunk();
    end
    send_byte(CODE_FEND);
    in_tvalid <= 1'b0;

    while (decoder_chk.decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoder_chk.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: slip_frame_decoder.f
sv/sfd_pkg.sv
sv/sfd_decode.sv
sv/slip_frame_decoder.sv
tb/tb_slip_frame_decoder.sv
